// File: rtl/core/daef_pkg.sv
// Shared widths, constants, register codes and state type for the decimating EWMA filter.
package daef_pkg;

  // Field widths
  localparam int CHAN_W    = 3;
  localparam int ADC_BITS  = 10;
  localparam int FRAC_BITS = 8;
  localparam int SUM_W     = 18;
  localparam int CNT_W     = 8;
  localparam int LVL_W     = 21;
  localparam int MV_W      = 13;
  localparam int FS_W      = 11;
  localparam int STR_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;

  // Datapath widths
  localparam int PROD_W    = MV_W + SUM_W;
  localparam int DVD_W     = PROD_W + FRAC_BITS;
  localparam int DVS_W     = FS_W;
  localparam int STEPS_W   = $clog2(DVD_W + 1);
  localparam int MUL_CNT_W = $clog2(SUM_W + 1);
  localparam int RELAX_W   = 5;
  localparam int F2_W      = STR_W + 1;
  localparam int JH_W      = LVL_W + 4;

  localparam int CHANNELS_DEF = 8;
  localparam int MV_FULL_SCALE = 5000;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MV_FULL_SCALE << FRAC_BITS);

  // Relax factor in halves: 8, 4, 1.5 and 1
  localparam logic [RELAX_W-1:0] RELAX_BIG   = RELAX_W'(16);
  localparam logic [RELAX_W-1:0] RELAX_MID   = RELAX_W'(8);
  localparam logic [RELAX_W-1:0] RELAX_SMALL = RELAX_W'(3);
  localparam logic [RELAX_W-1:0] RELAX_NONE  = RELAX_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_STRENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_JUMP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_JUMP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_JUMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF            = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE      = 3'd6;

  // Register reset values
  localparam logic [CNT_W-1:0] NUM_SAMPLES_RST     = 8'd10;
  localparam logic [STR_W-1:0] FILTER_STRENGTH_RST = 8'd16;
  localparam logic [MV_W-1:0]  BIG_JUMP_RST        = 13'd100;
  localparam logic [MV_W-1:0]  MID_JUMP_RST        = 13'd50;
  localparam logic [MV_W-1:0]  SMALL_JUMP_RST      = 13'd10;
  localparam logic [MV_W-1:0]  VREF_RST            = 13'd3300;
  localparam logic [FS_W-1:0]  FULL_SCALE_RST      = 11'd1023;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_AVG,
    ST_MUL,
    ST_LVL,
    ST_JUMP,
    ST_SCALE,
    ST_STEP,
    ST_OUT
  } daef_state_t;

endpackage

// File: rtl/core/decimating_adaptive_ewma_filter_top.sv
// Top level of the decimating adaptive EWMA filter for a multiplexed sensor ADC.
// A request that does not close its window is only accumulated, and the next is taken after it.
// A window-closing request runs through load, average division, serial multiply, millivolt
// division, jump, EWMA step division (skipped when the divisor would fall below one) and
// handover, which waits for the output to be free; the next request is taken after that.
// The single bit-serial divider is shared by all divisions. Synchronous reset clears all channel state.
module decimating_adaptive_ewma_filter_top import daef_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Sample requests
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic [CHAN_W-1:0]    chan,
  input  logic [ADC_BITS-1:0]  sample_code,
  // Result requests
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [CHAN_W-1:0]    out_chan,
  output logic [LVL_W-1:0]     unfiltered_level,
  output logic [LVL_W-1:0]     filtered_level,
  // Configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [CNT_W-1:0] num_samples;
  logic [STR_W-1:0] filter_strength;
  logic [MV_W-1:0]  big_jump_mv;
  logic [MV_W-1:0]  mid_jump_mv;
  logic [MV_W-1:0]  small_jump_mv;
  logic [MV_W-1:0]  vref_mv;
  logic [FS_W-1:0]  adc_full_scale;

  // Per-channel state, cleared by reset
  logic [SUM_W-1:0] sum_mem [CHANNELS];
  logic [CNT_W-1:0] cnt_mem [CHANNELS];
  logic [LVL_W-1:0] lvl_mem [CHANNELS];

  daef_state_t state;
  daef_state_t state_next;

  // Held request and working registers
  logic [CHAN_W-1:0]   chan_r;
  logic [ADC_BITS-1:0] code_r;
  logic [LVL_W-1:0]    last_r;
  logic [LVL_W-1:0]    u_r;
  logic [LVL_W-1:0]    jump_r;
  logic                up_r;
  logic [LVL_W-1:0]    f_r;

  logic [CH_IDX_W-1:0] idx;
  logic                chan_ok;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    n_eff;
  logic [FS_W-1:0]     fs_eff;
  logic                complete;
  logic                out_free;

  logic [RELAX_W-1:0]  relax;
  logic [JH_W-1:0]     jh;
  logic [F2_W-1:0]     f2;
  logic                bypass;

  // Serial units: one divider shared by all divisions, and one multiplier
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [STEPS_W-1:0] div_steps;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_p;

  daef_sdiv u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  daef_smul u_smul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (vref_mv),
    .mplier  (div_q[SUM_W-1:0]),
    .done    (mul_done),
    .product (mul_p)
  );

  // Configuration write port; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples     <= NUM_SAMPLES_RST;
      filter_strength <= FILTER_STRENGTH_RST;
      big_jump_mv     <= BIG_JUMP_RST;
      mid_jump_mv     <= MID_JUMP_RST;
      small_jump_mv   <= SMALL_JUMP_RST;
      vref_mv         <= VREF_RST;
      adc_full_scale  <= FULL_SCALE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NUM_SAMPLES:     num_samples     <= cfg_data[CNT_W-1:0];
        CFG_FILTER_STRENGTH: filter_strength <= cfg_data[STR_W-1:0];
        CFG_BIG_JUMP:        big_jump_mv     <= cfg_data[MV_W-1:0];
        CFG_MID_JUMP:        mid_jump_mv     <= cfg_data[MV_W-1:0];
        CFG_SMALL_JUMP:      small_jump_mv   <= cfg_data[MV_W-1:0];
        CFG_VREF:            vref_mv         <= cfg_data[MV_W-1:0];
        CFG_FULL_SCALE:      adc_full_scale  <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Window bookkeeping for the held request; zero window length or full scale acts as one
  always_comb begin
    idx      = CH_IDX_W'(chan_r);
    chan_ok  = (32'(chan_r) < CHANNELS);
    n_eff    = (num_samples == '0) ? CNT_W'(1) : num_samples;
    fs_eff   = (adc_full_scale == '0) ? FS_W'(1) : adc_full_scale;
    sum_wide = {1'b0, sum_mem[idx]} + (SUM_W + 1)'(code_r);
    sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    cnt_inc  = cnt_mem[idx] + 1'b1;
    // A count that wrapped to zero or passed a lowered window length also closes it
    complete = chan_ok && ((cnt_inc >= n_eff) || (cnt_inc == '0));
    out_free = !result_valid || result_ready;
  end

  // Jump classification: relax factor in halves, and jump scaled by it
  always_comb begin
    f2 = {filter_strength, 1'b0};
    priority if (jump_r > {big_jump_mv, FRAC_BITS'(0)}) begin
      relax = RELAX_BIG;
      jh    = {jump_r, 4'b0};
    end else if (jump_r > {mid_jump_mv, FRAC_BITS'(0)}) begin
      relax = RELAX_MID;
      jh    = {1'b0, jump_r, 3'b0};
    end else if (jump_r > {small_jump_mv, FRAC_BITS'(0)}) begin
      relax = RELAX_SMALL;
      jh    = {3'b0, jump_r, 1'b0} + {4'b0, jump_r};
    end else begin
      relax = RELAX_NONE;
      jh    = {3'b0, jump_r, 1'b0};
    end
    // Divisor would fall below one: take the new level as it is
    bypass = (f2 < F2_W'(relax));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sample_valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = complete ? ST_AVG : ST_IDLE;
      ST_AVG:   if (div_done) state_next = ST_MUL;
      ST_MUL:   if (mul_done) state_next = ST_LVL;
      ST_LVL:   if (div_done) state_next = ST_JUMP;
      ST_JUMP:  state_next = ST_SCALE;
      ST_SCALE: state_next = bypass ? ST_OUT : ST_STEP;
      ST_STEP:  if (div_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and launches of the serial units with their operands
  always_comb begin
    sample_ready = (state == ST_IDLE);
    mul_start    = (state == ST_AVG) && div_done;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    unique case (state)
      ST_LOAD: begin
        // Average: sum / window length, sum left-aligned
        div_start    = complete;
        div_dividend = {sum_new, (DVD_W - SUM_W)'(0)};
        div_divisor  = DVS_W'(n_eff);
        div_steps    = STEPS_W'(SUM_W);
      end
      ST_MUL: begin
        // Millivolts: vref * avg * 2^FRAC_BITS / full scale
        div_start    = mul_done;
        div_dividend = {mul_p, FRAC_BITS'(0)};
        div_divisor  = fs_eff;
        div_steps    = STEPS_W'(DVD_W);
      end
      ST_SCALE: begin
        // EWMA step: jump * relax / (2 * strength)
        div_start    = !bypass;
        div_dividend = {jh, (DVD_W - JH_W)'(0)};
        div_divisor  = DVS_W'(f2);
        div_steps    = STEPS_W'(JH_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      chan_r <= chan;
      code_r <= sample_code;
    end
    if (state == ST_LOAD) begin
      last_r <= lvl_mem[idx];
    end
    if (state == ST_LVL && div_done) begin
      // Saturate at full scale
      u_r <= (div_q > DVD_W'(LVL_MAX)) ? LVL_MAX : div_q[LVL_W-1:0];
    end
    if (state == ST_JUMP) begin
      jump_r <= (u_r > last_r) ? (u_r - last_r) : (last_r - u_r);
      up_r   <= (u_r > last_r);
    end
    if (state == ST_SCALE && bypass) begin
      f_r <= u_r;
    end
    if (state == ST_STEP && div_done) begin
      // Move the last level toward the new one by the step
      f_r <= up_r ? (last_r + div_q[LVL_W-1:0]) : (last_r - div_q[LVL_W-1:0]);
    end
  end

  // Channel state: advance an open window, or clear it once its result is handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_mem[i] <= '0;
        cnt_mem[i] <= '0;
        lvl_mem[i] <= '0;
      end
    end else if (state == ST_LOAD && chan_ok && !complete) begin
      sum_mem[idx] <= sum_new;
      cnt_mem[idx] <= cnt_inc;
    end else if (state == ST_OUT && out_free) begin
      sum_mem[idx] <= '0;
      cnt_mem[idx] <= '0;
      lvl_mem[idx] <= f_r;
    end
  end

  // Output register: hold the result until taken, refill in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_chan         <= chan_r;
      unfiltered_level <= u_r;
      filtered_level   <= f_r;
    end
  end

endmodule

// File: rtl/core/daef_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module daef_sdiv import daef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  input  logic [STEPS_W-1:0] steps,
  output logic               done,
  output logic [DVD_W-1:0]   quotient
);

  logic               busy;
  logic [STEPS_W-1:0] left;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   rem;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     diff;
  logic               ge;
  logic [DVS_W-1:0]   rem_next;

  // Bring down the next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == STEPS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

// File: rtl/core/daef_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module daef_smul import daef_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MV_W-1:0]   mcand,
  input  logic [SUM_W-1:0]  mplier,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] left;
  logic [PROD_W-1:0]    mc;
  logic [SUM_W-1:0]     mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= MUL_CNT_W'(SUM_W);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc      <= PROD_W'(mcand);
      mp      <= mplier;
      product <= '0;
    end else if (busy) begin
      if (mp[0]) begin
        product <= product + mc;
      end
      mc <= {mc[PROD_W-2:0], 1'b0};
      mp <= {1'b0, mp[SUM_W-1:1]};
    end
  end

endmodule
